FILE: hdl/csl_pkg.sv
// Shared types, constants and character helpers for the C source lexer.
// No dependencies; imported by c_source_lexer_unit.
package csl_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int LINE_BITS     = 20;
    localparam int KEYWORD_COUNT = 17;
    localparam int KW_SLOTS      = 32;

    localparam logic [OFFSET_BITS-1:0] CNT_TOP  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
    localparam logic [63:0]            NUM_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]            NUM_LIM_LO = 64'd922337203685477580;
    localparam logic [63:0]            NUM_LIM_HI = 64'd922337203685477579;
    localparam logic [7:0]             ESC_BYTE = 8'd27;

    typedef enum logic [4:0] {
        MODE_IDLE, MODE_SLASH, MODE_LCOM, MODE_BCOM, MODE_BSTAR, MODE_IDENT,
        MODE_NUM, MODE_PUNCT, MODE_STR, MODE_SESC, MODE_SOCT, MODE_SHEX0,
        MODE_SHEX, MODE_SFAIL, MODE_SFESC, MODE_CHR, MODE_CESC, MODE_COCT,
        MODE_CHEX0, MODE_CHEX, MODE_CEND
    } mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT, KIND_RES, KIND_NUM, KIND_STR, KIND_BYTE, KIND_END, KIND_ERR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_INVALID, ERR_COMMENT, ERR_STR, ERR_CHR, ERR_LONG, ERR_HEX, ERR_RANGE
    } err_t;

    typedef struct packed {
        mode_t                  mode;
        logic [OFFSET_BITS-1:0] token_start;
        logic [LINE_BITS-1:0]   token_line;
        logic [63:0]            number_accum;
        logic [8:0]             escape_accum;
        logic [1:0]             escape_digits;
        logic [63:0]            ident_prefix;
        logic [OFFSET_BITS-1:0] content_count;
        logic [7:0]             pending_punct;
        logic                   halted;
        err_t                   held_code;
        logic [OFFSET_BITS-1:0] held_pos;
        logic [LINE_BITS-1:0]   held_line;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode: MODE_IDLE, token_start: '0, token_line: LINE_BITS'(1),
        number_accum: '0, escape_accum: '0, escape_digits: '0,
        ident_prefix: '0, content_count: '0, pending_punct: '0,
        halted: 1'b0, held_code: ERR_INVALID, held_pos: '0, held_line: '0
    };

    typedef struct packed {
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] start_res;
        logic [OFFSET_BITS-1:0] length;
        logic [LINE_BITS-1:0]   line;
        logic [63:0]            value;
        logic                   kw_flag;
        err_t                   error_code;
    } res_t;

    typedef struct packed {
        lex_state_t st;
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
        logic       again;
    } pass_t;

    function automatic res_t mk_res(kind_t k, logic [OFFSET_BITS-1:0] st,
                                    logic [OFFSET_BITS-1:0] ln,
                                    logic [LINE_BITS-1:0] li, logic [63:0] v,
                                    logic kw, err_t e);
        res_t r;
        r.kind       = k;
        r.start_res  = st;
        r.length     = ln;
        r.line       = li;
        r.value      = v;
        r.kw_flag    = kw;
        r.error_code = e;
        return r;
    endfunction

    function automatic logic alpha_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] h;
        h = '0;
        if (is_digit(c))
            h = {1'b1, 4'(c - "0")};
        else if (c >= "a" && c <= "f")
            h = {1'b1, 4'(c - "a" + 8'd10)};
        else if (c >= "A" && c <= "F")
            h = {1'b1, 4'(c - "A" + 8'd10)};
        return h;
    endfunction

    function automatic logic [7:0] named_escape(logic [7:0] c);
        logic [7:0] r;
        case (c)
            "a":     r = 8'd7;
            "b":     r = 8'd8;
            "t":     r = 8'd9;
            "n":     r = 8'd10;
            "v":     r = 8'd11;
            "f":     r = 8'd12;
            "r":     r = 8'd13;
            "e":     r = ESC_BYTE;
            default: r = c;
        endcase
        return r;
    endfunction

    // keyword spelled big-endian, zero in the unused high bytes
    function automatic logic [63:0] kw_pack(int i);
        logic [63:0] p;
        unique case (i)
            0:       p = 64'("return");
            1:       p = 64'("if");
            2:       p = 64'("else");
            3:       p = 64'("for");
            4:       p = 64'("while");
            5:       p = 64'("int");
            6:       p = 64'("sizeof");
            7:       p = 64'("char");
            8:       p = 64'("struct");
            9:       p = 64'("union");
            10:      p = 64'("short");
            11:      p = 64'("long");
            12:      p = 64'("void");
            13:      p = 64'("typedef");
            14:      p = 64'("_Bool");
            15:      p = 64'("enum");
            16:      p = 64'("static");
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/c_source_lexer_unit.sv
// C source lexer: one source byte per item in, token records out.
// Each accepted byte is registered on input, then its records are registered into the result queue.
// Throughput: one byte per cycle while records drain as fast as they come; a byte is
// taken only with three free slots in the four-entry result queue, and the input is
// held while the queue lacks them.
// Reset: asynchronous, clears lexer state, position, line count and the queue; uses csl_pkg.
module c_source_lexer_unit
    import csl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // ch
    input  logic         s_tuser,   // at_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // start_res, length, line, value, kw_flag, error_code
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast
);

    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LINE_BITS-1:0]   ln_t;

    typedef struct packed {
        res_t r;
        logic last;
    } entry_t;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       end_reg;

    lex_state_t state_reg, state_next;
    off_t       pos_reg, pos_next;
    ln_t        line_reg, line_next;

    entry_t     fifo_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;

    logic       pop, room, consume;
    logic [1:0] push_n;
    res_t       lst [3];
    logic [1:0] n_total;
    pass_t      p1, p2, fin;

    function automatic res_t ident_res(lex_state_t s, off_t pos);
        logic found;
        logic [63:0] idx;
        found = 1'b0;
        idx = '0;
        for (int i = KW_SLOTS - 1; i >= 0; i--)
        begin
            if (i < KEYWORD_COUNT && s.content_count <= off_t'(8) &&
                kw_pack(i) == s.ident_prefix)
            begin
                found = 1'b1;
                idx = 64'(i);
            end
        end
        if (found)
            return mk_res(KIND_RES, s.token_start, pos - s.token_start, s.token_line,
                          idx, 1'b1, ERR_INVALID);
        return mk_res(KIND_IDENT, s.token_start, pos - s.token_start, s.token_line,
                      '0, 1'b0, ERR_INVALID);
    endfunction

    function automatic off_t bump(off_t v);
        return (v < CNT_TOP) ? v + off_t'(1) : v;
    endfunction

    function automatic pass_t lex_pass(lex_state_t s_in, logic [7:0] c, off_t pos, ln_t lc);
        pass_t       o;
        lex_state_t  s;
        logic [4:0]  h;
        logic [11:0] r;
        logic [63:0] lim;
        s = s_in;
        o.r0 = '0;
        o.r1 = '0;
        o.n = 2'd0;
        o.again = 1'b0;
        h = hex_val(c);
        r = {s.escape_accum[7:0], h[3:0]};
        lim = (c <= "7") ? NUM_LIM_LO : NUM_LIM_HI;
        case (s.mode)
            MODE_IDLE:
            begin
                if (!is_space(c))
                begin
                    s.token_start = pos;
                    s.token_line = lc;
                    if (c == "/")
                        s.mode = MODE_SLASH;
                    else if (c == "\"")
                    begin
                        s.content_count = '0;
                        s.mode = MODE_STR;
                    end
                    else if (c == "'")
                        s.mode = MODE_CHR;
                    else if (alpha_char(c))
                    begin
                        s.ident_prefix = 64'(c);
                        s.content_count = off_t'(1);
                        s.mode = MODE_IDENT;
                    end
                    else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "-")
                    begin
                        s.pending_punct = c;
                        s.mode = MODE_PUNCT;
                    end
                    else if (is_punct(c))
                    begin
                        o.r0 = mk_res(KIND_RES, pos, off_t'(1), lc, 64'(c), 1'b0, ERR_INVALID);
                        o.n = 2'd1;
                    end
                    else if (is_digit(c))
                    begin
                        s.number_accum = 64'(c - "0");
                        s.mode = MODE_NUM;
                    end
                    else
                    begin
                        o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_INVALID);
                        o.n = 2'd1;
                        s.halted = 1'b1;
                    end
                end
            end
            MODE_SLASH:
            begin
                if (c == "/")
                    s.mode = MODE_LCOM;
                else if (c == "*")
                    s.mode = MODE_BCOM;
                else
                begin
                    s.pending_punct = "/";
                    o.r0 = mk_res(KIND_RES, s.token_start, off_t'(1), s.token_line,
                                  64'("/"), 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    s.mode = MODE_IDLE;
                    o.again = 1'b1;
                end
            end
            MODE_LCOM:  if (c == "\n") s.mode = MODE_IDLE;
            MODE_BCOM:  if (c == "*") s.mode = MODE_BSTAR;
            MODE_BSTAR:
            begin
                if (c == "/")
                    s.mode = MODE_IDLE;
                else if (c != "*")
                    s.mode = MODE_BCOM;
            end
            MODE_IDENT:
            begin
                if (alpha_char(c) || is_digit(c))
                begin
                    if (s.content_count < off_t'(8))
                        s.ident_prefix = {s.ident_prefix[55:0], c};
                    s.content_count = bump(s.content_count);
                end
                else
                begin
                    o.r0 = ident_res(s, pos);
                    o.n = 2'd1;
                    s.mode = MODE_IDLE;
                    o.again = 1'b1;
                end
            end
            MODE_NUM:
            begin
                if (is_digit(c))
                begin
                    if (s.number_accum > lim)
                        s.number_accum = NUM_TOP;
                    else
                        s.number_accum = (s.number_accum << 3) + (s.number_accum << 1)
                                         + 64'(c - "0");
                end
                else
                begin
                    o.r0 = mk_res(KIND_NUM, s.token_start, pos - s.token_start,
                                  s.token_line, s.number_accum, 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    s.mode = MODE_IDLE;
                    o.again = 1'b1;
                end
            end
            MODE_PUNCT:
            begin
                if ((c == "=" && s.pending_punct != "-") ||
                    (c == ">" && s.pending_punct == "-"))
                begin
                    o.r0 = mk_res(KIND_RES, s.token_start, off_t'(2), s.token_line,
                                  64'({s.pending_punct, c}), 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                end
                else
                begin
                    o.r0 = mk_res(KIND_RES, s.token_start, off_t'(1), s.token_line,
                                  64'(s.pending_punct), 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    o.again = 1'b1;
                end
                s.mode = MODE_IDLE;
            end
            MODE_STR:
            begin
                if (c == "\"")
                begin
                    o.r0 = mk_res(KIND_BYTE, s.token_start, '0, s.token_line, '0,
                                  1'b0, ERR_INVALID);
                    s.content_count = bump(s.content_count);
                    o.r1 = mk_res(KIND_STR, s.token_start, pos - s.token_start + off_t'(1),
                                  s.token_line, 64'(s.content_count), 1'b0, ERR_INVALID);
                    o.n = 2'd2;
                    s.mode = MODE_IDLE;
                end
                else if (c == "\\")
                    s.mode = MODE_SESC;
                else
                begin
                    o.r0 = mk_res(KIND_BYTE, s.token_start, '0, s.token_line, 64'(c),
                                  1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    s.content_count = bump(s.content_count);
                end
            end
            MODE_SESC, MODE_CESC:
            begin
                if (is_octal(c))
                begin
                    s.escape_accum = 9'(c - "0");
                    s.escape_digits = 2'd1;
                    s.mode = (s_in.mode == MODE_SESC) ? MODE_SOCT : MODE_COCT;
                end
                else if (c == "x")
                begin
                    s.escape_accum = '0;
                    s.mode = (s_in.mode == MODE_SESC) ? MODE_SHEX0 : MODE_CHEX0;
                end
                else if (s_in.mode == MODE_SESC)
                begin
                    o.r0 = mk_res(KIND_BYTE, s.token_start, '0, s.token_line,
                                  64'(named_escape(c)), 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    s.content_count = bump(s.content_count);
                    s.mode = MODE_STR;
                end
                else
                begin
                    s.number_accum = 64'(named_escape(c));
                    s.mode = MODE_CEND;
                end
            end
            MODE_SOCT, MODE_COCT:
            begin
                if (is_octal(c))
                begin
                    s.escape_accum = {s.escape_accum[5:0], 3'(c - "0")};
                    s.escape_digits = s.escape_digits + 2'd1;
                end
                else
                    o.again = 1'b1;
                if (!is_octal(c) || s.escape_digits == 2'd3)
                begin
                    if (s_in.mode == MODE_SOCT)
                    begin
                        o.r0 = mk_res(KIND_BYTE, s.token_start, '0, s.token_line,
                                      64'(s.escape_accum[7:0]), 1'b0, ERR_INVALID);
                        o.n = 2'd1;
                        s.content_count = bump(s.content_count);
                        s.mode = MODE_STR;
                    end
                    else
                    begin
                        s.number_accum = 64'(s.escape_accum[7:0]);
                        s.mode = MODE_CEND;
                    end
                end
            end
            MODE_SHEX0, MODE_SHEX, MODE_CHEX0, MODE_CHEX:
            begin
                if (h[4])
                begin
                    if (s.mode == MODE_SHEX0 || s.mode == MODE_SHEX)
                    begin
                        if (r > 12'd255)
                        begin
                            s.held_code = ERR_RANGE;
                            s.held_pos = pos;
                            s.held_line = lc;
                            s.mode = MODE_SFAIL;
                            o.again = 1'b1;
                        end
                        else
                        begin
                            s.escape_accum = 9'(r);
                            s.mode = MODE_SHEX;
                        end
                    end
                    else if (r > 12'd255)
                    begin
                        o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_RANGE);
                        o.n = 2'd1;
                        s.halted = 1'b1;
                        s.mode = MODE_IDLE;
                    end
                    else
                    begin
                        s.escape_accum = 9'(r);
                        s.mode = MODE_CHEX;
                    end
                end
                else if (s.mode == MODE_SHEX0)
                begin
                    s.held_code = ERR_HEX;
                    s.held_pos = pos;
                    s.held_line = lc;
                    s.mode = MODE_SFAIL;
                    o.again = 1'b1;
                end
                else if (s.mode == MODE_CHEX0)
                begin
                    o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_HEX);
                    o.n = 2'd1;
                    s.halted = 1'b1;
                    s.mode = MODE_IDLE;
                end
                else if (s.mode == MODE_SHEX)
                begin
                    o.r0 = mk_res(KIND_BYTE, s.token_start, '0, s.token_line,
                                  64'(s.escape_accum[7:0]), 1'b0, ERR_INVALID);
                    o.n = 2'd1;
                    s.content_count = bump(s.content_count);
                    s.mode = MODE_STR;
                    o.again = 1'b1;
                end
                else
                begin
                    s.number_accum = 64'(s.escape_accum[7:0]);
                    s.mode = MODE_CEND;
                    o.again = 1'b1;
                end
            end
            MODE_SFAIL:
            begin
                if (c == "\"")
                begin
                    o.r0 = mk_res(KIND_ERR, s.held_pos, '0, s.held_line, '0, 1'b0,
                                  s.held_code);
                    o.n = 2'd1;
                    s.halted = 1'b1;
                    s.mode = MODE_IDLE;
                end
                else if (c == "\\")
                    s.mode = MODE_SFESC;
            end
            MODE_SFESC: s.mode = MODE_SFAIL;
            MODE_CHR:
            begin
                if (c == "\\")
                    s.mode = MODE_CESC;
                else
                begin
                    s.number_accum = 64'(c);
                    s.mode = MODE_CEND;
                end
            end
            MODE_CEND:
            begin
                if (c == "'")
                    o.r0 = mk_res(KIND_NUM, s.token_start, pos - s.token_start + off_t'(1),
                                  s.token_line, {{56{s.number_accum[7]}}, s.number_accum[7:0]},
                                  1'b0, ERR_INVALID);
                else
                begin
                    o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_LONG);
                    s.halted = 1'b1;
                end
                o.n = 2'd1;
                s.mode = MODE_IDLE;
            end
            default: s.mode = MODE_IDLE;
        endcase
        o.st = s;
        return o;
    endfunction

    // flush whatever token is open at end of input
    function automatic pass_t finish(lex_state_t s, off_t pos, ln_t lc);
        pass_t o;
        o.st = s;
        o.r0 = '0;
        o.r1 = '0;
        o.n = 2'd1;
        o.again = 1'b0;
        case (s.mode)
            MODE_SLASH:
                o.r0 = mk_res(KIND_RES, s.token_start, off_t'(1), s.token_line, 64'("/"),
                              1'b0, ERR_INVALID);
            MODE_BCOM, MODE_BSTAR:
                o.r0 = mk_res(KIND_ERR, s.token_start, '0, s.token_line, '0, 1'b0,
                              ERR_COMMENT);
            MODE_IDENT:
                o.r0 = ident_res(s, pos);
            MODE_NUM:
                o.r0 = mk_res(KIND_NUM, s.token_start, pos - s.token_start, s.token_line,
                              s.number_accum, 1'b0, ERR_INVALID);
            MODE_PUNCT:
                o.r0 = mk_res(KIND_RES, s.token_start, off_t'(1), s.token_line,
                              64'(s.pending_punct), 1'b0, ERR_INVALID);
            MODE_STR, MODE_SESC, MODE_SOCT, MODE_SHEX0, MODE_SHEX, MODE_SFAIL,
            MODE_SFESC:
                o.r0 = mk_res(KIND_ERR, s.token_start, '0, s.token_line, '0, 1'b0, ERR_STR);
            MODE_CHR, MODE_CESC:
                o.r0 = mk_res(KIND_ERR, s.token_start, '0, s.token_line, '0, 1'b0, ERR_CHR);
            MODE_CHEX0:
                o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_HEX);
            MODE_COCT, MODE_CHEX, MODE_CEND:
                o.r0 = mk_res(KIND_ERR, pos, '0, lc, '0, 1'b0, ERR_LONG);
            default:
                o.n = 2'd0;
        endcase
        if (s.halted)
            o.n = 2'd0;
        return o;
    endfunction

    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg - 3'(pop)) <= 3'd1;
    assign consume  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || consume;

    always_comb
    begin
        res_t end_res;
        end_res = mk_res(KIND_END, pos_reg, '0, line_reg, '0, 1'b0, ERR_INVALID);
        p1 = lex_pass(state_reg, ch_reg, pos_reg, line_reg);
        p2 = lex_pass(p1.st, ch_reg, pos_reg, line_reg);
        fin = finish(state_reg, pos_reg, line_reg);
        lst[0] = '0;
        lst[1] = '0;
        lst[2] = '0;
        state_next = state_reg;
        pos_next = pos_reg;
        line_next = line_reg;
        n_total = 2'd0;
        if (end_reg)
        begin
            lst[0] = (fin.n != 2'd0) ? fin.r0 : end_res;
            lst[1] = end_res;
            n_total = fin.n + 2'd1;
            state_next = LEX_RESET;
            pos_next = '0;
            line_next = ln_t'(1);
        end
        else
        begin
            if (!state_reg.halted)
            begin
                if (p1.again && !p1.st.halted)
                begin
                    state_next = p2.st;
                    if (p1.n != 2'd0)
                    begin
                        lst[0] = p1.r0;
                        lst[1] = p2.r0;
                        lst[2] = p2.r1;
                    end
                    else
                    begin
                        lst[0] = p2.r0;
                        lst[1] = p2.r1;
                    end
                    n_total = p1.n + p2.n;
                end
                else
                begin
                    state_next = p1.st;
                    lst[0] = p1.r0;
                    lst[1] = p1.r1;
                    n_total = p1.n;
                end
            end
            pos_next = pos_reg + off_t'(1);
            if (ch_reg == "\n" && line_reg < LINE_TOP)
                line_next = line_reg + ln_t'(1);
        end
        push_n = consume ? n_total : 2'd0;
        count_next = count_reg - 3'(pop) + 3'(push_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg <= LEX_RESET;
            pos_reg <= '0;
            line_reg <= ln_t'(1);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (consume)
            begin
                state_reg <= state_next;
                pos_reg <= pos_next;
                line_reg <= line_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // payload: input byte and result queue entries
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg <= s_tdata;
            end_reg <= s_tuser;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < push_n)
            begin
                fifo_reg[wr_ptr_reg + 2'(i)].r <= lst[i];
                fifo_reg[wr_ptr_reg + 2'(i)].last <= (2'(i) == push_n - 2'd1);
            end
        end
    end

    assign m_tvalid = count_reg != 3'd0;
    assign m_tuser  = fifo_reg[rd_ptr_reg].r.kind;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;
    assign m_tdata  = {fifo_reg[rd_ptr_reg].r.error_code, fifo_reg[rd_ptr_reg].r.kw_flag,
                       fifo_reg[rd_ptr_reg].r.value, fifo_reg[rd_ptr_reg].r.line,
                       fifo_reg[rd_ptr_reg].r.length, fifo_reg[rd_ptr_reg].r.start_res};

endmodule
